// File: rtl/deque_with_reverse_unit_macros.svh
// assertion macros for the deque with reverse unit
`ifndef DEQUE_WITH_REVERSE_UNIT_MACROS_SVH
`define DEQUE_WITH_REVERSE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define DWR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true at a clock edge out of reset
`define DWR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DWR_ASSERT(label, clk, rst_n, prop, msg)
`define DWR_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/dwr_pkg.sv
// shared types and constants of the deque with reverse unit
package dwr_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned DATA_W        = 32;

  // raw command codes on the input channel
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_REAR   = 3'd3;
  localparam logic [2:0] CMD_REVERSE    = 3'd4;
  localparam logic [2:0] CMD_LIST       = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // classified operation
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_REV  = 3'd2,
    OP_LIST = 3'd3,
    OP_NOP  = 3'd4
  } op_t;

  // one classified word handed from front to back
  typedef struct packed {
    op_t                      op;
    logic                     to_front;
    logic signed [DATA_W-1:0] value;
  } item_t;

endpackage

// File: rtl/dwr_ram.sv
// generic single-write, single-read ram with registered read data
module dwr_ram #(
  parameter int unsigned WIDTH = dwr_pkg::DATA_W,
  parameter int unsigned DEPTH = dwr_pkg::DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dwr_front.sv
// front end: accepts command words, classifies them and queues them for the back end
module dwr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_cmd,
  input  logic signed [dwr_pkg::DATA_W-1:0] in_value,
  output logic                             q_valid,
  output dwr_pkg::item_t                   q_item,
  input  logic                             q_pop
);

  dwr_pkg::item_t mem_r [2];
  dwr_pkg::item_t cls;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           push, pop;

  // classify the raw command
  always_comb begin
    cls.value    = in_value;
    cls.to_front = 1'b0;
    unique case (in_cmd)
      dwr_pkg::CMD_PUSH_FRONT: begin
        cls.op       = dwr_pkg::OP_PUSH;
        cls.to_front = 1'b1;
      end
      dwr_pkg::CMD_PUSH_REAR: begin
        cls.op = dwr_pkg::OP_PUSH;
      end
      dwr_pkg::CMD_POP_FRONT: begin
        cls.op       = dwr_pkg::OP_POP;
        cls.to_front = 1'b1;
      end
      dwr_pkg::CMD_POP_REAR: begin
        cls.op = dwr_pkg::OP_POP;
      end
      dwr_pkg::CMD_REVERSE: begin
        cls.op = dwr_pkg::OP_REV;
      end
      dwr_pkg::CMD_LIST: begin
        cls.op = dwr_pkg::OP_LIST;
      end
      default: begin
        cls.op = dwr_pkg::OP_NOP;
      end
    endcase
  end

  // two-entry queue handshake
  assign in_stall = (fill_r == 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: rtl/dwr_back.sv
// back end: executes queued commands on the ring buffer and drives the result register
`include "deque_with_reverse_unit_macros.svh"
module dwr_back #(
  parameter int unsigned DEPTH = dwr_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  dwr_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic                              out_has_data,
  output logic signed [dwr_pkg::DATA_W-1:0] out_data,
  output logic                              out_last
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW:0]   WRAP     = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] TOP_SLOT = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            rev_r, rev_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            list_r, list_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            has_data_r, has_data_nxt;
  logic [dwr_pkg::DATA_W-1:0] data_r, data_nxt;
  logic            last_r, last_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [dwr_pkg::DATA_W-1:0] ram_rdata;

  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   head_dec;
  logic            at_low;
  logic            is_full, is_empty;
  logic [AW-1:0]   list_off;
  logic [AW-1:0]   idx_inc;

  // ring slot: head plus offset, wrapped once
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW-1:0] o);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, o};
    if (s >= WRAP) begin
      s = s - WRAP;
    end
    return s[AW-1:0];
  endfunction

  dwr_ram #(
    .WIDTH (dwr_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_item.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // helpers for end positions
  assign cnt_m1   = count_r - CW'(1);
  assign head_dec = (head_r == '0) ? TOP_SLOT : head_r - AW'(1);
  assign at_low   = q_item.to_front ^ rev_r;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);
  assign idx_inc  = idx_r + AW'(1);
  assign list_off = rev_r ? (cnt_m1[AW-1:0] - idx_inc) : idx_inc;

  // command sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    rev_nxt      = rev_r;
    idx_nxt      = idx_r;
    list_nxt     = list_r;
    status_nxt   = status_r;
    has_data_nxt = has_data_r;
    data_nxt     = data_r;
    last_nxt     = last_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = at_low ? head_dec : slot(head_r, count_r[AW-1:0]);
    ram_raddr    = at_low ? head_r : slot(head_r, cnt_m1[AW-1:0]);

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          status_nxt   = dwr_pkg::ST_OK;
          has_data_nxt = 1'b0;
          data_nxt     = '0;
          last_nxt     = 1'b1;
          list_nxt     = 1'b0;
          state_nxt    = S_EMIT;
          unique case (q_item.op)
            dwr_pkg::OP_PUSH: begin
              if (is_full) begin
                status_nxt = dwr_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                if (at_low) begin
                  head_nxt = head_dec;
                end
              end
            end
            dwr_pkg::OP_POP: begin
              if (is_empty) begin
                status_nxt = dwr_pkg::ST_EMPTY;
              end else begin
                count_nxt = cnt_m1;
                state_nxt = S_RD;
                if (at_low) begin
                  head_nxt = slot(head_r, AW'(1));
                end
              end
            end
            dwr_pkg::OP_REV: begin
              rev_nxt = !rev_r;
            end
            dwr_pkg::OP_LIST: begin
              if (is_empty) begin
                status_nxt = dwr_pkg::ST_EMPTY;
              end else begin
                list_nxt  = 1'b1;
                idx_nxt   = '0;
                ram_raddr = rev_r ? slot(head_r, cnt_m1[AW-1:0]) : head_r;
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        has_data_nxt = 1'b1;
        data_nxt     = ram_rdata;
        last_nxt     = !list_r || ((CW'(idx_r) + CW'(1)) == count_r);
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (list_r && !last_r) begin
            idx_nxt   = idx_inc;
            ram_raddr = slot(head_r, list_off);
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      list_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      list_r  <= list_nxt;
    end
  end

  // result payload and list index
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    has_data_r <= has_data_nxt;
    data_r     <= data_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid    = (state_r == S_EMIT);
  assign out_status   = status_r;
  assign out_has_data = has_data_r;
  assign out_data     = data_r;
  assign out_last     = last_r;

  // checks
  `DWR_ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > FULL_CNT, "element count above depth")
  `DWR_ASSERT(a_push_grows, clk, rst_n, (state_r == S_IDLE && q_valid && q_item.op == dwr_pkg::OP_PUSH && !is_full) |=> (count_r == $past(count_r) + CW'(1)), "push did not grow count")
  `DWR_ASSERT(a_rev_toggles, clk, rst_n, (state_r == S_IDLE && q_valid && q_item.op == dwr_pkg::OP_REV) |=> (rev_r != $past(rev_r)), "reverse did not toggle flag")
  `DWR_ASSERT(a_rd_to_emit, clk, rst_n, (state_r == S_RD) |=> (state_r == S_EMIT && out_has_data), "read did not produce a data word")

endmodule

// File: rtl/deque_with_reverse_unit.sv
// Bounded double-ended queue of signed 32-bit words with constant-time reverse.
// Input channel (in_valid/in_stall, in_cmd, in_value) takes one command word:
// push front, push rear, pop front, pop rear, reverse, list all.
// Result channel (out_valid/out_stall) gives out_status, out_has_data, out_data
// and out_last; every command gives one word, list gives one per stored element.
// A two-entry command queue sits in front of the execution sequencer, so new
// commands are taken while a result waits on out_stall.
// Path from accept to result: the command queue entry, then the result register for
// push, reverse and empty cases; a pop with data also passes S_RD (registered ram read).
// Each command runs to its last result word before the next is taken; list reads one
// element per result word, as the sequencer issues one ram read and one result word at a time.
// A stalled result holds its payload; the sequencer waits and the command queue
// fills, then in_stall rises.
// Reset (rst_n low, synchronous) empties the queue, clears head, count and the
// reverse flag; the element store needs no clearing.
module deque_with_reverse_unit #(
  parameter int unsigned DEPTH = dwr_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_cmd,
  input  logic signed [dwr_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic                              out_has_data,
  output logic signed [dwr_pkg::DATA_W-1:0] out_data,
  output logic                              out_last
);

  logic           q_valid;
  logic           q_pop;
  dwr_pkg::item_t q_item;

  // command intake and queue
  dwr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // execution and result register
  dwr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_has_data (out_has_data),
    .out_data     (out_data),
    .out_last     (out_last)
  );

endmodule
